// ===== rtl/orcw_pkg.sv =====
// Shared types, constants and helpers for the occupancy ray cell walker.
// No dependencies; every other file imports this package.
`default_nettype none
package orcw_pkg;

  localparam int unsigned MAP_CELLS = 64;
  localparam int unsigned CELL_W    = $clog2(MAP_CELLS);
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned SIZE_W    = 7;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned HDIV_W    = COORD_W + 1;
  localparam int unsigned HACC_W    = COORD_W + 2;
  localparam int unsigned DCNT_W    = $clog2(HDIV_W);

  localparam logic [IDX_W-1:0] REG_ENABLED = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN_X   = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_Y   = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_X   = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_Y   = 3'd4;
  localparam logic [IDX_W-1:0] REG_CPM     = 3'd5;
  localparam logic [IDX_W-1:0] REG_WIDTH   = 3'd6;
  localparam logic [IDX_W-1:0] REG_HEIGHT  = 3'd7;

  localparam logic [COORD_W-1:0] CPM_RESET  = 32'd1310720;
  localparam logic [SIZE_W-1:0]  SIZE_RESET = SIZE_W'(MAP_CELLS);

  typedef enum logic [0:0] {
    K_HIT,
    K_RAY
  } kind_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SUB,
    F_MUL,
    F_CLAMP,
    F_CLASS,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_HIT,
    B_ABS,
    B_DIV,
    B_PREP,
    B_WALK
  } back_state_e;

  typedef struct packed {
    logic                      enabled;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic [COORD_W-1:0]        cpm;
    logic [CELL_W-1:0]         top_x;
    logic [CELL_W-1:0]         top_y;
  } cfg_t;

  typedef struct packed {
    kind_e                     kind;
    logic                      occ;
    logic [CELL_W-1:0]         cx;
    logic [CELL_W-1:0]         cy;
    logic                      y_major;
    logic                      maj_neg;
    logic                      min_neg;
    logic [CELL_W-1:0]         amaj;
    logic [CELL_W-1:0]         amin;
    logic signed [COORD_W-1:0] hp;
    logic signed [COORD_W-1:0] hs;
  } desc_t;

  function automatic logic [CELL_W-1:0] size_top(input logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] c;
    c = n;
    if (c == '0) c = SIZE_W'(1);
    if (c > SIZE_W'(MAP_CELLS)) c = SIZE_W'(MAP_CELLS);
    return CELL_W'(c - SIZE_W'(1));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/orcw_fifo.sv =====
// Two-entry queue of ray/hit descriptors between front and back.
// Depends on orcw_pkg.
`default_nettype none
module orcw_fifo (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  orcw_pkg::desc_t    data_i,
  output logic               full_o,
  input  wire                pop_i,
  output logic               empty_o,
  output orcw_pkg::desc_t    data_o
);
  import orcw_pkg::*;

  desc_t      mem_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = do_push ? !wptr_q : wptr_q;
    rptr_d = do_pop ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end

endmodule
`default_nettype wire

// ===== rtl/orcw_front.sv =====
// Front end: accepts items, maps points to cells and classifies rays.
// Depends on orcw_pkg; feeds orcw_fifo.
`default_nettype none
module orcw_front (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  orcw_pkg::cfg_t                   cfg_i,
  input  wire                              push_i,
  output logic                             full_o,
  input  wire                              func_i,
  input  wire                              hit_i,
  input  wire  [orcw_pkg::COORD_W-1:0]     point_x_i,
  input  wire  [orcw_pkg::COORD_W-1:0]     point_y_i,
  input  wire  [orcw_pkg::COORD_W-1:0]     sensor_x_i,
  input  wire  [orcw_pkg::COORD_W-1:0]     sensor_y_i,
  input  wire  [orcw_pkg::COORD_W-1:0]     point_height_i,
  input  wire  [orcw_pkg::COORD_W-1:0]     sensor_height_i,
  output logic                             q_push_o,
  output orcw_pkg::desc_t                  q_data_o,
  input  wire                              q_full_i
);
  import orcw_pkg::*;

  front_state_e               state_q, state_d;
  logic [1:0]                 ci_q;
  logic                       func_q, hit_q;
  logic signed [COORD_W-1:0]  coord_q [4];
  logic signed [COORD_W-1:0]  hp_q, hs_q;
  logic [COORD_W-1:0]         d_q;
  logic [2*COORD_W-1:0]       prod_q;
  logic [CELL_W-1:0]          cell_q [4];
  desc_t                      desc_q;

  logic signed [COORD_W-1:0]  c_sel, lo_sel, hi_sel;
  logic [CELL_W-1:0]          top_sel, idx;
  logic [COORD_W-1:0]         cells;
  logic                       inb, last_coord;
  logic signed [CELL_W:0]     dx, dy;
  logic [CELL_W-1:0]          adx, ady;
  logic                       y_major;
  logic [CELL_W-1:0]          amaj;

  always_comb begin
    c_sel      = coord_q[ci_q];
    lo_sel     = ci_q[0] ? cfg_i.min_y : cfg_i.min_x;
    hi_sel     = ci_q[0] ? cfg_i.max_y : cfg_i.max_x;
    top_sel    = ci_q[0] ? cfg_i.top_y : cfg_i.top_x;
    inb        = (c_sel >= lo_sel) && (c_sel <= hi_sel);
    cells      = prod_q[2*COORD_W-1:COORD_W];
    idx        = (cells > COORD_W'(top_sel)) ? top_sel : cells[CELL_W-1:0];
    last_coord = func_q ? (ci_q == 2'd3) : (ci_q == 2'd1);
    dx         = $signed({1'b0, cell_q[0]}) - $signed({1'b0, cell_q[2]});
    dy         = $signed({1'b0, cell_q[1]}) - $signed({1'b0, cell_q[3]});
    adx        = dx[CELL_W] ? CELL_W'(-dx) : dx[CELL_W-1:0];
    ady        = dy[CELL_W] ? CELL_W'(-dy) : dy[CELL_W-1:0];
    y_major    = ady > adx;
    amaj       = y_major ? ady : adx;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:  if (push_i && cfg_i.enabled) state_d = F_SUB;
      F_SUB:   state_d = inb ? F_MUL : F_IDLE;
      F_MUL:   state_d = F_CLAMP;
      F_CLAMP: begin
        if (!last_coord) state_d = F_SUB;
        else state_d = func_q ? F_CLASS : F_PUSH;
      end
      F_CLASS: state_d = (amaj > CELL_W'(1)) ? F_PUSH : F_IDLE;
      F_PUSH:  if (!q_full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    full_o   = state_q != F_IDLE;
    q_push_o = state_q == F_PUSH;
    q_data_o = desc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      ci_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      if (state_q == F_IDLE) ci_q <= 2'd0;
      else if (state_q == F_CLAMP) ci_q <= ci_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        func_q     <= func_i;
        hit_q      <= hit_i;
        coord_q[0] <= point_x_i;
        coord_q[1] <= point_y_i;
        coord_q[2] <= sensor_x_i;
        coord_q[3] <= sensor_y_i;
        hp_q       <= point_height_i;
        hs_q       <= sensor_height_i;
      end
      F_SUB:   d_q <= COORD_W'(c_sel - lo_sel);
      F_MUL:   prod_q <= d_q * cfg_i.cpm;
      F_CLAMP: begin
        cell_q[ci_q] <= idx;
        desc_q.kind  <= K_HIT;
        desc_q.occ   <= hit_q;
        desc_q.cx    <= cell_q[0];
        desc_q.cy    <= ci_q[0] ? idx : cell_q[1];
        desc_q.hp    <= hp_q;
        desc_q.hs    <= hs_q;
      end
      F_CLASS: begin
        desc_q.kind    <= K_RAY;
        desc_q.occ     <= 1'b0;
        desc_q.cx      <= cell_q[2];
        desc_q.cy      <= cell_q[3];
        desc_q.y_major <= y_major;
        desc_q.maj_neg <= y_major ? dy[CELL_W] : dx[CELL_W];
        desc_q.min_neg <= y_major ? dx[CELL_W] : dy[CELL_W];
        desc_q.amaj    <= amaj;
        desc_q.amin    <= y_major ? adx : ady;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/orcw_back.sv =====
// Back end: walks rays with running remainders and emits cell updates.
// Depends on orcw_pkg; drains orcw_fifo.
`default_nettype none
module orcw_back (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              q_empty_i,
  input  orcw_pkg::desc_t                  q_data_i,
  output logic                             q_pop_o,
  output logic                             empty,
  input  wire                              pop,
  output logic [orcw_pkg::CELL_W-1:0]      cell_x_o,
  output logic [orcw_pkg::CELL_W-1:0]      cell_y_o,
  output logic                             occupied_o,
  output logic [orcw_pkg::COORD_W-1:0]     cell_height_o,
  output logic                             last_o
);
  import orcw_pkg::*;

  back_state_e               state_q, state_d;
  desc_t                     desc_q;
  logic signed [HDIV_W-1:0]  hdiff_q;
  logic                      hneg_q;
  logic [HDIV_W-1:0]         div_q;
  logic [CELL_W-1:0]         rem_q;
  logic [DCNT_W-1:0]         cnt_q;
  logic [HACC_W-1:0]         stepq_q, stepq1_q;
  logic signed [HACC_W-1:0]  h_q;
  logic [CELL_W-1:0]         k_q, qo_q;
  logic [CELL_W+1:0]         ro_q, rh_q;

  logic                      ovalid_q;
  logic [CELL_W-1:0]         ocx_q, ocy_q;
  logic                      oocc_q, olast_q;
  logic [COORD_W-1:0]        oh_q;

  logic                      can_load, emit, walk_last;
  logic [CELL_W:0]           t, two_maj;
  logic                      ge;
  logic [CELL_W+1:0]         ro_s, rh_s, ro_n, rh_n;
  logic                      co, ch;
  logic [CELL_W-1:0]         qo_n;
  logic signed [HACC_W-1:0]  h_n;
  logic [CELL_W:0]           off, kk, minor_c, major_c;
  logic [HACC_W-1:0]         qwide;

  always_comb begin
    can_load  = !ovalid_q || pop;
    two_maj   = {desc_q.amaj, 1'b0};
    walk_last = k_q == (desc_q.amaj - CELL_W'(1));
    t         = {rem_q, div_q[HDIV_W-1]};
    ge        = t >= {1'b0, desc_q.amaj};
    qwide     = {1'b0, div_q};
    ro_s      = ro_q + {1'b0, desc_q.amin, 1'b0};
    co        = ro_s >= {1'b0, two_maj};
    ro_n      = co ? ro_s - {1'b0, two_maj} : ro_s;
    qo_n      = qo_q + CELL_W'(co);
    rh_s      = rh_q + {1'b0, rem_q, 1'b0};
    ch        = rh_s >= {1'b0, two_maj};
    rh_n      = ch ? rh_s - {1'b0, two_maj} : rh_s;
    h_n       = h_q + $signed(ch ? stepq1_q : stepq_q);
    off       = desc_q.min_neg ? -{1'b0, qo_n} : {1'b0, qo_n};
    kk        = desc_q.maj_neg ? -{1'b0, k_q} : {1'b0, k_q};
    minor_c   = (desc_q.y_major ? {1'b0, desc_q.cx} : {1'b0, desc_q.cy}) + off;
    major_c   = (desc_q.y_major ? {1'b0, desc_q.cy} : {1'b0, desc_q.cx}) + kk;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (!q_empty_i) state_d = (q_data_i.kind == K_HIT) ? B_HIT : B_ABS;
      end
      B_HIT:  if (can_load) state_d = B_IDLE;
      B_ABS:  state_d = B_DIV;
      B_DIV:  if (cnt_q == DCNT_W'(HDIV_W - 1)) state_d = B_PREP;
      B_PREP: state_d = B_WALK;
      B_WALK: if (can_load && walk_last) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o       = (state_q == B_IDLE) && !q_empty_i;
    emit          = can_load && ((state_q == B_HIT) || (state_q == B_WALK));
    empty         = !ovalid_q;
    cell_x_o      = ocx_q;
    cell_y_o      = ocy_q;
    occupied_o    = oocc_q;
    cell_height_o = oh_q;
    last_o        = olast_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) ovalid_q <= 1'b1;
      else if (pop) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        desc_q  <= q_data_i;
        hdiff_q <= HDIV_W'(q_data_i.hp) - HDIV_W'(q_data_i.hs);
      end
      B_ABS: begin
        hneg_q <= hdiff_q[HDIV_W-1];
        div_q  <= hdiff_q[HDIV_W-1] ? HDIV_W'(-hdiff_q) : hdiff_q;
        rem_q  <= '0;
        cnt_q  <= '0;
      end
      B_DIV: begin
        rem_q <= ge ? CELL_W'(t - {1'b0, desc_q.amaj}) : t[CELL_W-1:0];
        div_q <= {div_q[HDIV_W-2:0], ge};
        cnt_q <= cnt_q + DCNT_W'(1);
      end
      B_PREP: begin
        stepq_q  <= hneg_q ? ~qwide + HACC_W'(1) : qwide;
        stepq1_q <= hneg_q ? ~qwide : qwide + HACC_W'(1);
        h_q      <= HACC_W'(desc_q.hs);
        k_q      <= CELL_W'(1);
        qo_q     <= '0;
        ro_q     <= {2'b00, desc_q.amaj};
        rh_q     <= {2'b00, desc_q.amaj};
      end
      B_WALK: begin
        if (can_load) begin
          k_q  <= k_q + CELL_W'(1);
          qo_q <= qo_n;
          ro_q <= ro_n;
          rh_q <= rh_n;
          h_q  <= h_n;
        end
      end
      default: ;
    endcase

    if (emit) begin
      if (state_q == B_HIT) begin
        ocx_q   <= desc_q.cx;
        ocy_q   <= desc_q.cy;
        oocc_q  <= desc_q.occ;
        oh_q    <= desc_q.hp;
        olast_q <= 1'b1;
      end else begin
        ocx_q   <= desc_q.y_major ? minor_c[CELL_W-1:0] : major_c[CELL_W-1:0];
        ocy_q   <= desc_q.y_major ? major_c[CELL_W-1:0] : minor_c[CELL_W-1:0];
        oocc_q  <= 1'b0;
        oh_q    <= h_n[COORD_W-1:0];
        olast_q <= walk_last;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/occupancy_ray_cell_walker.sv =====
// Top level: configuration registers, front end, descriptor queue, back end.
// Depends on orcw_pkg, orcw_front, orcw_fifo and orcw_back.
//
// Converts lidar returns into occupancy grid cell updates. A point item
// (func_i low) maps one point to a cell and yields a single update; a ray
// item yields one free-cell update per cell strictly between sensor and
// return point along the major axis. The front end maps each coordinate by
// a bound check, a 32x32 multiply and a clamp on one shared multiplier, and
// holds full high while it works, so it takes no new item before it is
// through with the last. The back end runs a serial divider per ray for the
// height slope, then emits one update per cycle while the result side takes
// them, up to 62 per ray. A two-deep descriptor queue lets the front map the
// next item while the back walks a ray.
`default_nettype none
module occupancy_ray_cell_walker (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [orcw_pkg::IDX_W-1:0]       cfg_idx_i,
  input  wire  [orcw_pkg::COORD_W-1:0]     cfg_wdata_i,
  input  wire                              push,
  output logic                             full,
  input  wire                              func_i,
  input  wire                              hit_i,
  input  wire  [orcw_pkg::COORD_W-1:0]     point_x_i,
  input  wire  [orcw_pkg::COORD_W-1:0]     point_y_i,
  input  wire  [orcw_pkg::COORD_W-1:0]     sensor_x_i,
  input  wire  [orcw_pkg::COORD_W-1:0]     sensor_y_i,
  input  wire  [orcw_pkg::COORD_W-1:0]     point_height_i,
  input  wire  [orcw_pkg::COORD_W-1:0]     sensor_height_i,
  output logic                             empty,
  input  wire                              pop,
  output logic [orcw_pkg::CELL_W-1:0]      cell_x_o,
  output logic [orcw_pkg::CELL_W-1:0]      cell_y_o,
  output logic                             occupied_o,
  output logic [orcw_pkg::COORD_W-1:0]     cell_height_o,
  output logic                             last_o
);
  import orcw_pkg::*;

  logic               en_q;
  logic [COORD_W-1:0] min_x_q, min_y_q, max_x_q, max_y_q, cpm_q;
  logic [SIZE_W-1:0]  width_q, height_q;
  cfg_t               cfg;
  logic               q_push, q_full, q_pop, q_empty;
  desc_t              q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b0;
      min_x_q  <= '0;
      min_y_q  <= '0;
      max_x_q  <= '0;
      max_y_q  <= '0;
      cpm_q    <= CPM_RESET;
      width_q  <= SIZE_RESET;
      height_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ENABLED: en_q     <= cfg_wdata_i[0];
        REG_MIN_X:   min_x_q  <= cfg_wdata_i;
        REG_MIN_Y:   min_y_q  <= cfg_wdata_i;
        REG_MAX_X:   max_x_q  <= cfg_wdata_i;
        REG_MAX_Y:   max_y_q  <= cfg_wdata_i;
        REG_CPM:     cpm_q    <= cfg_wdata_i;
        REG_WIDTH:   width_q  <= cfg_wdata_i[SIZE_W-1:0];
        REG_HEIGHT:  height_q <= cfg_wdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.enabled = en_q;
    cfg.min_x   = min_x_q;
    cfg.min_y   = min_y_q;
    cfg.max_x   = max_x_q;
    cfg.max_y   = max_y_q;
    cfg.cpm     = cpm_q;
    cfg.top_x   = size_top(width_q);
    cfg.top_y   = size_top(height_q);
  end

  orcw_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .push_i          (push),
    .full_o          (full),
    .func_i          (func_i),
    .hit_i           (hit_i),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .sensor_x_i      (sensor_x_i),
    .sensor_y_i      (sensor_y_i),
    .point_height_i  (point_height_i),
    .sensor_height_i (sensor_height_i),
    .q_push_o        (q_push),
    .q_data_o        (q_wdata),
    .q_full_i        (q_full)
  );

  orcw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  orcw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .empty         (empty),
    .pop           (pop),
    .cell_x_o      (cell_x_o),
    .cell_y_o      (cell_y_o),
    .occupied_o    (occupied_o),
    .cell_height_o (cell_height_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire

// ===== rtl/orcw_checker.sv =====
// Port-level checks for occupancy_ray_cell_walker, bound to the top level.
// Depends on orcw_pkg.
`default_nettype none
module orcw_checker (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             empty,
  input wire                             pop,
  input wire [orcw_pkg::CELL_W-1:0]      cell_x_o,
  input wire [orcw_pkg::CELL_W-1:0]      cell_y_o,
  input wire                             occupied_o,
  input wire [orcw_pkg::COORD_W-1:0]     cell_height_o,
  input wire                             last_o
);
  import orcw_pkg::*;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result dropped without pop");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(cell_x_o) && $stable(cell_y_o) &&
                       $stable(cell_height_o) && $stable(last_o))
    else $error("stalled result changed");

  a_hit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && occupied_o |-> last_o)
    else $error("occupied update not marked last");

  a_result_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !$isunknown({cell_x_o, cell_y_o, occupied_o, cell_height_o, last_o}))
    else $error("waiting result has unknown bits");

endmodule

bind occupancy_ray_cell_walker orcw_checker u_orcw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .cell_x_o      (cell_x_o),
  .cell_y_o      (cell_y_o),
  .occupied_o    (occupied_o),
  .cell_height_o (cell_height_o),
  .last_o        (last_o)
);
`default_nettype wire
